/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended queue
// Request and status codes, fixed port field widths and the command
// bundle from controller to datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

    // fixed port field widths
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // request codes (codes above POP_FRONT act as peek)
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // controller commands to the datapath
    typedef struct packed {
        logic load;     // take a request: update pointers, count, store
        logic capture;  // read front and back entries into output registers
    } t_dq_cmd;

endpackage

/* sv/double_ended_queue.sv */
// A request accepted while idle moves the controller into its read state, and
//   o_valid is registered from that state; a new request is held off by busy
//   until the store's registered read of the front and back entries is done.
// busy is high for the one cycle of the store read.
// Reset (i_rst_n low, synchronous) empties the queue; stored values are not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque in a circular buffer
// Push or pop at either end, or peek; every request reports front, back,
// entry count, empty flag and an overflow/underflow status.
// ----------------------------------------------------------------------------
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [VALUE_W-1:0]  i_push_value,
    output logic                o_valid,
    output logic [VALUE_W-1:0]  o_front_value,
    output logic [VALUE_W-1:0]  o_back_value,
    output logic [COUNT_W-1:0]  o_entry_count,
    output logic                o_is_empty,
    output logic [STATUS_W-1:0] o_status
);

    t_dq_cmd cmd;

    // sequence requests
    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // store and pointers
    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_push_value  (i_push_value),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    // an accepted request always goes into the read cycle
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter the store read");

    // every read cycle ends in exactly one result strobe
    a_read_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("store read not followed by a result strobe");

    // an empty queue reports zero values
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_front_value == '0 && o_back_value == '0))
        else $error("empty queue reported nonzero values");

    // a full-store overflow cannot leave the queue empty
    a_overflow_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OVERFLOW) |-> !o_is_empty)
        else $error("overflow reported on an empty queue");

endmodule

/* sv/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl: request sequencer
// Accepts a request when idle, reads the store in its read state and
// strobes the result in the cycle after that.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_valid,
    output t_dq_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state;
    logic n_state;
    logic r_valid;

    // hold off new requests while the store read is in flight
    assign busy    = (r_state == S_READ);
    assign o_valid = r_valid;

    assign o_cmd.load    = start && (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_READ);

    // advance state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_READ);
        end
    end

endmodule

/* sv/dq_datapath.sv */
// ----------------------------------------------------------------------------
// dq_datapath: ring store, pointers and entry count
// Applies one request per load command and reads the front and back
// entries into output registers on a capture command.
// ----------------------------------------------------------------------------
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dq_cmd             i_cmd,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [VALUE_W-1:0]  i_push_value,
    output logic [VALUE_W-1:0]  o_front_value,
    output logic [VALUE_W-1:0]  o_back_value,
    output logic [COUNT_W-1:0]  o_entry_count,
    output logic                o_is_empty,
    output logic [STATUS_W-1:0] o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [AW-1:0]         r_front;
    logic [AW-1:0]         n_front;
    logic [AW-1:0]         r_back;
    logic [AW-1:0]         n_back;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic [DATA_WIDTH-1:0] r_rd_front;
    logic [DATA_WIDTH-1:0] r_rd_back;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;
    logic [AW-1:0]         back_dec;
    logic [AW-1:0]         back_inc;
    logic                  full;
    logic                  empty;
    logic [63:0]           push_ext;
    logic [63:0]           rd_front_ext;
    logic [63:0]           rd_back_ext;
    logic [31:0]           count_ext;

    // wrap pointers around the ring
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign back_dec  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;
    assign back_inc  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;

    assign full  = (r_count == FULL_CNT);
    assign empty = (r_count == '0);

    assign push_ext = 64'(i_push_value);
    assign wr_data  = push_ext[DATA_WIDTH-1:0];

    // decode the request
    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = r_back;
        priority if (i_req_type == REQ_PUSH_BACK || i_req_type == REQ_PUSH_FRONT) begin
            if (full) begin
                n_status = ST_OVERFLOW;
            end else if (i_req_type == REQ_PUSH_BACK) begin
                wr_en   = 1'b1;
                wr_addr = r_back;
                n_back  = back_inc;
                n_count = r_count + 1'b1;
            end else begin
                wr_en   = 1'b1;
                wr_addr = front_dec;
                n_front = front_dec;
                n_count = r_count + 1'b1;
            end
        end else if (i_req_type == REQ_POP_BACK || i_req_type == REQ_POP_FRONT) begin
            if (empty) begin
                n_status = ST_UNDERFLOW;
            end else if (i_req_type == REQ_POP_BACK) begin
                n_back  = back_dec;
                n_count = r_count - 1'b1;
            end else begin
                n_front = front_inc;
                n_count = r_count - 1'b1;
            end
        end else begin
            n_status = ST_OK;
        end
    end

    // update pointers, count and status on load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_back   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
        end else if (i_cmd.load) begin
            r_front  <= n_front;
            r_back   <= n_back;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    // write the pushed value
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // read front and back entries after the pointer update
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_front <= r_mem[r_front];
            r_rd_back  <= r_mem[back_dec];
        end
    end

    // zero the values when the store is empty
    assign rd_front_ext  = 64'(r_rd_front);
    assign rd_back_ext   = 64'(r_rd_back);
    assign count_ext     = 32'(r_count);
    assign o_front_value = empty ? '0 : rd_front_ext[VALUE_W-1:0];
    assign o_back_value  = empty ? '0 : rd_back_ext[VALUE_W-1:0];
    assign o_entry_count = count_ext[COUNT_W-1:0];
    assign o_is_empty    = empty;
    assign o_status      = r_status;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: request-level check of the double-ended queue
// Drives push, pop and peek requests with random idle gaps, mirrors the
// deque in a small tracker class and compares every reported front, back,
// count, empty flag and status against the mirrored contents.
// ----------------------------------------------------------------------------
module testbench;
    import dq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // keep only the stored width of a pushed value
    localparam logic [VALUE_W-1:0] VALUE_MASK =
        (DATA_WIDTH >= VALUE_W) ? '1 : VALUE_W'((64'd1 << DATA_WIDTH) - 64'd1);

    // request codes outside the defined set; the block treats them as peek
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef struct {
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
        logic [COUNT_W-1:0]  entry_count;
        logic                is_empty;
        logic [STATUS_W-1:0] status;
    } t_deque_report;

    // Mirror of the deque contents plus the queue of reports still owed
    class t_deque_tracker;
        logic [VALUE_W-1:0] ring [DEPTH];
        int                 front_idx;
        int                 back_idx;
        int                 occupancy;
        t_deque_report      owed_reports[$];
        int                 mismatches;

        function new();
            front_idx  = 0;
            back_idx   = 0;
            occupancy  = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction

        // Apply one accepted request to the mirror and queue its report
        function void note_request(logic [REQ_W-1:0] req, logic [VALUE_W-1:0] value);
            t_deque_report rpt;
            logic [VALUE_W-1:0] masked;
            masked     = value & VALUE_MASK;
            rpt.status = ST_OK;
            case (req)
                REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                    if (occupancy >= DEPTH) begin
                        rpt.status = ST_OVERFLOW;
                    end else if (req == REQ_PUSH_BACK) begin
                        ring[back_idx] = masked;
                        back_idx       = (back_idx + 1) % DEPTH;
                        occupancy++;
                    end else begin
                        front_idx       = (front_idx + DEPTH - 1) % DEPTH;
                        ring[front_idx] = masked;
                        occupancy++;
                    end
                end
                REQ_POP_BACK, REQ_POP_FRONT: begin
                    if (occupancy == 0) begin
                        rpt.status = ST_UNDERFLOW;
                    end else if (req == REQ_POP_BACK) begin
                        back_idx = (back_idx + DEPTH - 1) % DEPTH;
                        occupancy--;
                    end else begin
                        front_idx = (front_idx + 1) % DEPTH;
                        occupancy--;
                    end
                end
                default: ;
            endcase
            // report the ends only when something is stored
            if (occupancy != 0) begin
                rpt.front_value = ring[front_idx];
                rpt.back_value  = ring[(back_idx + DEPTH - 1) % DEPTH];
            end else begin
                rpt.front_value = '0;
                rpt.back_value  = '0;
            end
            rpt.entry_count = occupancy[COUNT_W-1:0];
            rpt.is_empty    = (occupancy == 0);
            owed_reports    = {owed_reports, rpt};
        endfunction

        // Compare one strobed report with the oldest owed one
        function void check_report(t_deque_report got);
            t_deque_report want;
            if (owed_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected report: front=%h back=%h count=%0d empty=%b st=%0d",
                             $time, got.front_value, got.back_value, got.entry_count,
                             got.is_empty, got.status);
                return;
            end
            want = owed_reports[0];
            owed_reports.delete(0);
            if (got.front_value !== want.front_value || got.back_value !== want.back_value ||
                got.entry_count !== want.entry_count || got.is_empty !== want.is_empty ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] report mismatch", $time);
                    $display("  expected front=%h back=%h count=%0d empty=%b st=%0d",
                             want.front_value, want.back_value, want.entry_count,
                             want.is_empty, want.status);
                    $display("  actual   front=%h back=%h count=%0d empty=%b st=%0d",
                             got.front_value, got.back_value, got.entry_count,
                             got.is_empty, got.status);
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [REQ_W-1:0]    i_req_type = REQ_PEEK;
    logic [VALUE_W-1:0]  i_push_value = '0;
    logic                o_valid;
    logic [VALUE_W-1:0]  o_front_value;
    logic [VALUE_W-1:0]  o_back_value;
    logic [COUNT_W-1:0]  o_entry_count;
    logic                o_is_empty;
    logic [STATUS_W-1:0] o_status;

    t_deque_tracker tracker;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watch both sides at the rising edge: check reports, then log requests
    always @(posedge i_clk) begin
        t_deque_report got;
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                got.front_value = o_front_value;
                got.back_value  = o_back_value;
                got.entry_count = o_entry_count;
                got.is_empty    = o_is_empty;
                got.status      = o_status;
                tracker.check_report(got);
            end
            if (start && busy === 1'b0)
                tracker.note_request(i_req_type, i_push_value);
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    // Request mix leaning toward filling or draining the queue
    function automatic logic [REQ_W-1:0] pick_request(bit filling);
        int r;
        bit side;
        r    = $urandom_range(99);
        side = 1'($urandom_range(1));
        if (r < 4) return REQ_W'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
        if (r < 14) return REQ_PEEK;
        if ($urandom_range(99) < (filling ? 75 : 25))
            return side ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        return side ? REQ_POP_FRONT : REQ_POP_BACK;
    endfunction

    // Hold off for gap cycles, then present one request until it is taken
    task automatic send_request(logic [REQ_W-1:0] req, logic [VALUE_W-1:0] value, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_req_type   <= req;
        i_push_value <= value;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    initial begin
        logic [VALUE_W-1:0] pattern [4];
        logic [VALUE_W-1:0] value;
        bit                 filling;
        bit                 steady;
        int                 phase_left;
        int                 guard;
        int                 leftover;

        tracker = new();
        pattern[0] = '0;
        pattern[1] = '1;
        pattern[2] = 32'hAAAA_AAAA;
        pattern[3] = 32'h5555_5555;

        // Hold reset from the start, release on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue: both pops underflow, peek reports zeros
        send_request(REQ_POP_BACK, '1, 0);
        send_request(REQ_POP_FRONT, '1, 1);
        send_request(REQ_PEEK, '0, 0);
        // Fill to the brim from both ends with extreme values
        for (int k = 0; k < DEPTH; k++)
            send_request((k % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pattern[k % 4], pick_gap());
        // Full queue: pushes drop, peek and spare codes leave it alone
        send_request(REQ_PUSH_BACK, 32'hDEAD_BEEF, 0);
        send_request(REQ_PUSH_FRONT, 32'hCAFE_F00D, 2);
        send_request(REQ_PEEK, '0, 0);
        send_request(REQ_SPARE_LO, '1, 0);
        send_request(REQ_SPARE_MID, '1, 0);
        send_request(REQ_SPARE_HI, '1, 0);

        // Random part: alternate fill and drain phases so both limits recur
        filling    = 1'b0;
        steady     = 1'b0;
        phase_left = 0;
        for (int n = 0; n < 600; n++) begin
            if (phase_left == 0) begin
                filling    = ~filling;
                steady     = ($urandom_range(3) == 0);
                phase_left = $urandom_range(60, 20);
            end
            phase_left--;
            case ($urandom_range(15))
                0:       value = '0;
                1:       value = '1;
                default: value = $urandom;
            endcase
            send_request(pick_request(filling), value, steady ? 0 : pick_gap());
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Drain outstanding reports, then let the pipe settle
        guard = 0;
        while (tracker.pending() != 0 && guard < 200) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);

        leftover = tracker.pending();
        if (leftover != 0)
            $display("%0d reports never arrived", leftover);
        if (tracker.mismatches == 0 && leftover == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Stop a hung run
    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
